// File: src/bounded_length_max_subarray_sum_unit_macros.svh
// Assertion macros shared by the bounded-length max subarray sum RTL
`ifndef BOUNDED_LENGTH_MAX_SUBARRAY_SUM_UNIT_MACROS_SVH
`define BOUNDED_LENGTH_MAX_SUBARRAY_SUM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BLMSS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BLMSS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/blmss_pkg.sv
// Shared constants and types of the bounded-length max subarray sum unit
`default_nettype none

package blmss_pkg;

  localparam int LEN_W     = 11;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 52;
  localparam int CFG_IDX_W = 2;
  localparam int Q_DEPTH   = 2;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;

  localparam logic [LEN_W-1:0] MIN_LEN_RST = 11'd1;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 11'd1024;

  localparam logic [SUM_W-1:0] SUM_MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

  // classification of one word, set by the front end
  typedef struct packed {
    logic counted;   // within the item limit of the sequence
    logic eligible;  // a start prefix enters the window
    logic j_zero;    // that start prefix is the empty prefix
    logic last;      // closes the sequence
  } item_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAIL,
    ST_HEAD,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// File: src/blmss_ram.sv
// Generic single-write, single-read RAM with registered read (write-first)
`default_nettype none

module blmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // a read of the address being written returns the new data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/blmss_fifo.sv
// Small register FIFO between front end and back end
`default_nettype none

`include "bounded_length_max_subarray_sum_unit_macros.svh"

module blmss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = slots[rd_ptr];
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);

  `BLMSS_ASSERT_NEXT(a_fifo_count_up, clk, rst, wr_en && !rd_en, count == $past(count) + 1'b1, "fifo count did not grow on write")
  `BLMSS_ASSERT_NEXT(a_fifo_count_dn, clk, rst, rd_en && !wr_en, count == $past(count) - 1'b1, "fifo count did not shrink on read")
  `BLMSS_ASSERT_IMP(a_fifo_no_under, clk, rst, rd_en, !empty, "fifo read while empty")

endmodule

`default_nettype wire

// File: src/blmss_front.sv
// Front end: running prefix, item count and ring indexes, classifies each word
`default_nettype none

module blmss_front #(
  parameter int MAX_WINDOW = 1024,
  parameter int MAX_ITEMS  = 1048576,
  localparam int PW = $clog2(MAX_ITEMS + 1),
  localparam int RW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_fire,
  input  logic signed [blmss_pkg::VAL_W-1:0]  sample_value,
  input  logic                                is_last,
  input  logic [RW-1:0]                       lo,
  output logic                                q_wr,
  output logic [blmss_pkg::SUM_W-1:0]         q_prefix,
  output logic [PW-1:0]                       q_i,
  output logic [PW-1:0]                       q_j,
  output logic [RW-1:0]                       q_i_idx,
  output logic [RW-1:0]                       q_j_idx,
  output blmss_pkg::item_flags_t              q_flags
);

  import blmss_pkg::*;

  localparam int RING_SIZE = MAX_WINDOW + 1;
  localparam int CW = ((PW > RW) ? PW : RW) + 1;

  logic [PW-1:0]    seen;
  logic [SUM_W-1:0] prefix;
  logic [RW-1:0]    idx;

  logic             counted;
  logic [PW-1:0]    i_val;
  logic [RW-1:0]    i_idx;
  logic [CW-1:0]    i_ext;
  logic [CW-1:0]    lo_ext;
  logic [CW-1:0]    j_ext;
  logic [RW:0]      j_wrap;
  logic [SUM_W-1:0] prefix_next;

  // classification of the incoming word
  always_comb begin
    counted     = (seen < PW'(MAX_ITEMS));
    i_val       = seen + 1'b1;
    i_idx       = (idx == RW'(RING_SIZE - 1)) ? '0 : idx + 1'b1;
    i_ext       = CW'(i_val);
    lo_ext      = CW'(lo);
    j_ext       = i_ext - lo_ext;
    j_wrap      = {1'b0, i_idx} + (RW+1)'(RING_SIZE) - {1'b0, lo};
    prefix_next = prefix + {{(SUM_W-VAL_W){sample_value[VAL_W-1]}}, sample_value};
  end

  assign q_wr             = in_fire;
  assign q_prefix         = prefix_next;
  assign q_i              = i_val;
  assign q_j              = j_ext[PW-1:0];
  assign q_i_idx          = i_idx;
  assign q_j_idx          = (i_idx >= lo) ? (i_idx - lo) : j_wrap[RW-1:0];
  assign q_flags.counted  = counted;
  assign q_flags.eligible = counted && (i_ext >= lo_ext);
  assign q_flags.j_zero   = (i_ext == lo_ext);
  assign q_flags.last     = is_last;

  // sequence state, restarted after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      prefix <= '0;
      idx    <= '0;
    end else if (in_fire) begin
      if (is_last) begin
        seen   <= '0;
        prefix <= '0;
        idx    <= '0;
      end else if (counted) begin
        seen   <= i_val;
        prefix <= prefix_next;
        idx    <= i_idx;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/blmss_back.sv
// Back end: monotone queue of start prefixes, prefix ring, best sum and result register
`default_nettype none

`include "bounded_length_max_subarray_sum_unit_macros.svh"

module blmss_back #(
  parameter int MAX_WINDOW = 1024,
  parameter int MAX_ITEMS  = 1048576,
  localparam int PW = $clog2(MAX_ITEMS + 1),
  localparam int RW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_rd,
  input  logic [blmss_pkg::SUM_W-1:0]  in_prefix,
  input  logic [PW-1:0]                in_i,
  input  logic [PW-1:0]                in_j,
  input  logic [RW-1:0]                in_i_idx,
  input  logic [RW-1:0]                in_j_idx,
  input  blmss_pkg::item_flags_t       in_flags,
  input  logic [RW-1:0]                hi,
  input  logic                         pop,
  output logic                         empty,
  output logic [blmss_pkg::SUM_W-1:0]  best_sum,
  output logic                         answer_valid
);

  import blmss_pkg::*;

  localparam int RING_SIZE = MAX_WINDOW + 1;
  localparam int CW = ((PW > RW) ? PW : RW) + 1;
  localparam int QW = PW + SUM_W;

  back_state_t      state;
  back_state_t      state_next;

  logic [RW-1:0]    head;
  logic [RW-1:0]    tail;

  // current word
  logic [SUM_W-1:0] it_prefix;
  logic [PW-1:0]    it_i;
  logic [PW-1:0]    it_j;
  logic [RW-1:0]    it_i_idx;
  item_flags_t      it_flags;

  logic [SUM_W-1:0] pj_reg;
  logic             pj_ok;
  logic [SUM_W-1:0] best;
  logic             found;

  logic             out_valid;
  logic [SUM_W-1:0] out_sum;
  logic             out_ok;

  // memory ports
  logic [SUM_W-1:0] ring_rdata;
  logic             ring_we;
  logic [RW-1:0]    q_raddr;
  logic [QW-1:0]    q_rdata;
  logic [PW-1:0]    q_rd_pos;
  logic [SUM_W-1:0] q_rd_pre;

  logic             q_nonempty;
  logic [RW-1:0]    tail_prev;
  logic [RW-1:0]    tail_prev2;
  logic [RW-1:0]    tail_next;
  logic [RW-1:0]    head_next;
  logic [RW-1:0]    head_after_push;
  logic [SUM_W-1:0] pj_cur;
  logic [SUM_W-1:0] cand;
  logic             tail_pop;
  logic             head_pop;
  logic             push;
  logic             full_push;
  logic             head_done;
  logic             update;
  logic             better;
  logic             out_free;
  logic             emit_load;

  function automatic logic [RW-1:0] wrap_next(input logic [RW-1:0] k);
    wrap_next = (k == RW'(RING_SIZE - 1)) ? '0 : k + 1'b1;
  endfunction

  function automatic logic [RW-1:0] wrap_prev(input logic [RW-1:0] k);
    wrap_prev = (k == '0) ? RW'(RING_SIZE - 1) : k - 1'b1;
  endfunction

  // queue bookkeeping and compares
  always_comb begin
    q_rd_pos        = q_rdata[SUM_W +: PW];
    q_rd_pre        = q_rdata[SUM_W-1:0];
    q_nonempty      = (head != tail);
    tail_prev       = wrap_prev(tail);
    tail_prev2      = wrap_prev(tail_prev);
    tail_next       = wrap_next(tail);
    head_next       = wrap_next(head);
    pj_cur          = pj_ok ? pj_reg : (it_flags.j_zero ? '0 : ring_rdata);
    tail_pop        = (state == ST_TAIL) && q_nonempty &&
                      ($signed(q_rd_pre) >= $signed(pj_cur));
    push            = (state == ST_TAIL) && !tail_pop;
    full_push       = push && (tail_next == head);
    head_after_push = full_push ? head_next : head;
    head_pop        = (state == ST_HEAD) && q_nonempty &&
                      ((CW'(q_rd_pos) + CW'(hi)) < CW'(it_i));
    head_done       = (state == ST_HEAD) && !head_pop;
    update          = head_done && it_flags.eligible && q_nonempty;
    cand            = it_prefix - q_rd_pre;
    better          = !found || ($signed(cand) > $signed(best));
    ring_we         = head_done && it_flags.counted;
    out_free        = !out_valid || pop;
    emit_load       = (state == ST_EMIT) && out_free;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, fifo read and queue read address
  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    q_raddr    = head;
    unique case (state)
      ST_IDLE: begin
        q_raddr = in_flags.eligible ? tail_prev : head;
        if (!q_empty) begin
          q_rd = 1'b1;
          if (!in_flags.counted) begin
            state_next = in_flags.last ? ST_EMIT : ST_IDLE;
          end else if (in_flags.eligible) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_HEAD;
          end
        end
      end
      ST_TAIL: begin
        q_raddr = tail_pop ? tail_prev2 : head_after_push;
        if (!tail_pop) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        q_raddr = head_next;
        if (!head_pop) begin
          state_next = it_flags.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // word capture
  always_ff @(posedge clk) begin
    if (q_rd) begin
      it_prefix <= in_prefix;
      it_i      <= in_i;
      it_j      <= in_j;
      it_i_idx  <= in_i_idx;
      it_flags  <= in_flags;
    end
    if (state == ST_TAIL) begin
      pj_reg <= pj_cur;
    end
  end

  // queue pointers, best sum, sequence restart
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      pj_ok <= 1'b0;
      best  <= SUM_MOST_NEG;
      found <= 1'b0;
    end else begin
      if (q_rd) begin
        pj_ok <= 1'b0;
      end else if (state == ST_TAIL) begin
        pj_ok <= 1'b1;
      end
      if (tail_pop) begin
        tail <= tail_prev;
      end else if (push) begin
        tail <= tail_next;
      end
      if (full_push || head_pop) begin
        head <= head_next;
      end
      if (update) begin
        found <= 1'b1;
        if (better) begin
          best <= cand;
        end
      end
      if (emit_load) begin
        head  <= '0;
        tail  <= '0;
        best  <= SUM_MOST_NEG;
        found <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_sum <= found ? best : '0;
      out_ok  <= found;
    end
  end

  assign empty        = !out_valid;
  assign best_sum     = out_sum;
  assign answer_valid = out_ok;

  // prefix ring: read the start prefix, write this word's prefix
  blmss_ram #(
    .WIDTH (SUM_W),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (it_i_idx),
    .wdata (it_prefix),
    .raddr (in_j_idx),
    .rdata (ring_rdata)
  );

  // monotone queue entries: position and prefix
  blmss_ram #(
    .WIDTH (QW),
    .DEPTH (RING_SIZE)
  ) u_queue (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata ({it_j, pj_cur}),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  `BLMSS_ASSERT_NEXT(a_push_nonempty, clk, rst, push, head != tail, "queue empty right after push")
  `BLMSS_ASSERT_NEXT(a_emit_restart, clk, rst, emit_load, (head == tail) && !found && out_valid, "sequence not restarted after result")
  `BLMSS_ASSERT_NEXT(a_head_pop_stay, clk, rst, head_pop, state == ST_HEAD, "left head scan while dropping")

endmodule

`default_nettype wire

// File: src/bounded_length_max_subarray_sum_unit.sv
// Bounded-length maximum subarray sum unit: top level
//
// Input words (sample_value, is_last) are pushed with push while full is low.
// Each word extends a running prefix; on the word with is_last set the unit
// queues one result: the largest sum of any run whose length lies between
// min_len and max_len (clamped to 1..MAX_WINDOW), with answer_valid low and
// best_sum zero if the sequence was shorter than min_len.
// Results are read like a queue: while empty is low the result is on
// best_sum / answer_valid, and pop takes it.
// Config: cfg_valid with cfg_index (0 = min_len, 1 = max_len) and cfg_data;
// cfg_ready is always high. Write only while the unit is idle.
// Timing: the front end takes a word per cycle, while full is low, into a 2-word
// queue. The back end only reads a word past the item limit, runs the head scan
// on a word shorter than min_len into the sequence and the tail then head scan
// on others, plus a step per queue entry dropped; each entry is dropped at most
// once, and the pace is set by the one-at-a-time walk of the candidate queue RAM.
// A result is loaded from the emit state once the output register is free.
// Reset clears sequence state and sets min_len = 1, max_len = 1024; memories
// need no clearing. A stalled result waits in the output register; the back
// end then holds at the next last word and the input queue fills up.
`default_nettype none

module bounded_length_max_subarray_sum_unit #(
  parameter int MAX_WINDOW = 1024,
  parameter int MAX_ITEMS  = 1048576,
  localparam int PW = $clog2(MAX_ITEMS + 1),
  localparam int RW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [blmss_pkg::VAL_W-1:0]   sample_value,
  input  logic                                 is_last,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [blmss_pkg::SUM_W-1:0]   best_sum,
  output logic                                 answer_valid,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [blmss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blmss_pkg::LEN_W-1:0]          cfg_data
);

  import blmss_pkg::*;

  localparam int CLW = (RW > LEN_W) ? RW : LEN_W;
  localparam int FLW = $bits(item_flags_t);
  localparam int DW  = SUM_W + 2 * PW + 2 * RW + FLW;

  logic [LEN_W-1:0] min_len;
  logic [LEN_W-1:0] max_len;
  logic [CLW-1:0]   mn_ext;
  logic [CLW-1:0]   mx_ext;
  logic [CLW-1:0]   lo_c;
  logic [CLW-1:0]   hi_c;
  logic [RW-1:0]    lo;
  logic [RW-1:0]    hi;

  logic             in_fire;
  logic             f_wr;
  logic [SUM_W-1:0] f_prefix;
  logic [PW-1:0]    f_i;
  logic [PW-1:0]    f_j;
  logic [RW-1:0]    f_i_idx;
  logic [RW-1:0]    f_j_idx;
  item_flags_t      f_flags;

  logic [DW-1:0]    q_wdata;
  logic [DW-1:0]    q_rdata;
  logic             q_empty;
  logic             q_rd;
  logic [SUM_W-1:0] b_prefix;
  logic [PW-1:0]    b_i;
  logic [PW-1:0]    b_j;
  logic [RW-1:0]    b_i_idx;
  logic [RW-1:0]    b_j_idx;
  item_flags_t      b_flags;
  logic [SUM_W-1:0] b_sum;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RST;
      max_len <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN_LEN) begin
        min_len <= cfg_data;
      end else if (cfg_index == CFG_MAX_LEN) begin
        max_len <= cfg_data;
      end
    end
  end

  // length clamping: lo in [1, MAX_WINDOW], hi in [lo, MAX_WINDOW]
  always_comb begin
    mn_ext = CLW'(min_len);
    mx_ext = CLW'(max_len);
    if (mn_ext == '0) begin
      lo_c = CLW'(1);
    end else if (mn_ext > CLW'(MAX_WINDOW)) begin
      lo_c = CLW'(MAX_WINDOW);
    end else begin
      lo_c = mn_ext;
    end
    if (mx_ext < lo_c) begin
      hi_c = lo_c;
    end else if (mx_ext > CLW'(MAX_WINDOW)) begin
      hi_c = CLW'(MAX_WINDOW);
    end else begin
      hi_c = mx_ext;
    end
    lo = lo_c[RW-1:0];
    hi = hi_c[RW-1:0];
  end

  assign in_fire = push && !full;

  blmss_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .sample_value (sample_value),
    .is_last      (is_last),
    .lo           (lo),
    .q_wr         (f_wr),
    .q_prefix     (f_prefix),
    .q_i          (f_i),
    .q_j          (f_j),
    .q_i_idx      (f_i_idx),
    .q_j_idx      (f_j_idx),
    .q_flags      (f_flags)
  );

  assign q_wdata = {f_prefix, f_i, f_j, f_i_idx, f_j_idx, f_flags};

  blmss_fifo #(
    .WIDTH (DW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_wr),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  assign {b_prefix, b_i, b_j, b_i_idx, b_j_idx, b_flags} = q_rdata;

  blmss_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .in_prefix    (b_prefix),
    .in_i         (b_i),
    .in_j         (b_j),
    .in_i_idx     (b_i_idx),
    .in_j_idx     (b_j_idx),
    .in_flags     (b_flags),
    .hi           (hi),
    .pop          (pop),
    .empty        (empty),
    .best_sum     (b_sum),
    .answer_valid (answer_valid)
  );

  assign best_sum = b_sum;

endmodule

`default_nettype wire

// File: tb/tb_bounded_length_max_subarray_sum_unit.sv
// Self-checking testbench for the bounded-length max subarray sum unit
`timescale 1ns / 100ps

module tb_bounded_length_max_subarray_sum_unit;
  import blmss_pkg::*;

  localparam int MAX_WINDOW   = 256;
  // item cap kept just above the window so that the cap is reachable in one run
  localparam int ITEM_CAP     = 300;
  localparam int RING         = MAX_WINDOW + 1;
  localparam int SETTLE       = 2500;   // a word may drop a full window of queue entries
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_WORDS = 780;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             last;
  } sample_word_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic                    ok;
  } run_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [VAL_W-1:0] sample_value = '0;
  logic is_last = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SUM_W-1:0] best_sum;
  logic answer_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;

  sample_word_t samples_to_send[$];
  run_answer_t  sums_due[$];

  bit steady = 1'b0;
  int errors = 0;
  int n_words = 0;
  int n_results = 0;
  int n_no_run = 0;
  int n_writes = 0;
  int quiet_cycles = 0;

  // predictor state: register copies, prefix ring, monotone queue of start prefixes
  int     min_len_cfg = MIN_LEN_RST;
  int     max_len_cfg = MAX_LEN_RST;
  longint acc = 0;
  longint ring_sum[RING] = '{default: 0};
  int     q_pos[RING] = '{default: 0};
  longint q_sum[RING] = '{default: 0};
  int     q_hd = 0;
  int     q_tl = 0;
  int     n_seen = 0;
  longint best = 0;
  bit     have_best = 1'b0;

  bounded_length_max_subarray_sum_unit #(
    .MAX_WINDOW(MAX_WINDOW),
    .MAX_ITEMS (ITEM_CAP)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample_value(sample_value),
    .is_last     (is_last),
    .empty       (empty),
    .pop         (pop),
    .best_sum    (best_sum),
    .answer_valid(answer_valid),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int ring_next(input int k);
    return (k + 1 >= RING) ? 0 : k + 1;
  endfunction

  function automatic int ring_prev(input int k);
    return (k == 0) ? RING - 1 : k - 1;
  endfunction

  function automatic void restart_run();
    acc = 0;
    ring_sum[0] = 0;
    q_hd = 0;
    q_tl = 0;
    n_seen = 0;
    have_best = 1'b0;
  endfunction

  // advance the running prefix by one word; a closing word yields the best run sum
  task automatic absorb_sample(input logic signed [VAL_W-1:0] v, input logic last);
    int lo;
    int hi;
    int i;
    int j;
    longint pj;
    longint cand;
    run_answer_t ans;
    lo = min_len_cfg;
    hi = max_len_cfg;
    if (lo < 1) lo = 1;
    if (lo > MAX_WINDOW) lo = MAX_WINDOW;
    if (hi < lo) hi = lo;
    if (hi > MAX_WINDOW) hi = MAX_WINDOW;
    if (n_seen < ITEM_CAP) begin
      i = n_seen + 1;
      n_seen = i;
      acc += v;
      if (i >= lo) begin
        j = i - lo;
        pj = ring_sum[j % RING];
        // tail entries at or above the new prefix can never be the minimum
        while (q_hd != q_tl && q_sum[ring_prev(q_tl)] >= pj) q_tl = ring_prev(q_tl);
        if (ring_next(q_tl) == q_hd) q_hd = ring_next(q_hd);
        q_pos[q_tl] = j;
        q_sum[q_tl] = pj;
        q_tl = ring_next(q_tl);
      end
      // head entries whose start fell out of the window
      while (q_hd != q_tl && q_pos[q_hd] + hi < i) q_hd = ring_next(q_hd);
      if (i >= lo && q_hd != q_tl) begin
        cand = acc - q_sum[q_hd];
        if (!have_best || cand > best) best = cand;
        have_best = 1'b1;
      end
      ring_sum[i % RING] = acc;
    end
    if (last) begin
      ans.sum = have_best ? best[SUM_W-1:0] : '0;
      ans.ok  = have_best;
      sums_due = {sums_due, ans};
      restart_run();
    end
  endtask

  // driver: offers the oldest pending word, idling at random
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) void'(samples_to_send.pop_front());
      if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
        push         <= 1'b1;
        sample_value <= samples_to_send[0].value;
        is_last      <= samples_to_send[0].last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: checks each result word, then feeds the accepted input word to the predictor
  always @(posedge clk) begin
    run_answer_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (sums_due.size() == 0) begin
          $error("unexpected result word: best_sum=%0d answer_valid=%0b",
                 best_sum, answer_valid);
          errors++;
        end else begin
          want = sums_due.pop_front();
          n_results++;
          if (!want.ok) n_no_run++;
          if (answer_valid !== want.ok) begin
            $error("answer_valid: expected %0b, got %0b", want.ok, answer_valid);
            errors++;
          end
          if (best_sum !== want.sum) begin
            $error("best_sum: expected %0d, got %0d", want.sum, best_sum);
            errors++;
          end
        end
      end
      if (push && !full) begin
        n_words++;
        absorb_sample(sample_value, is_last);
      end
      pop <= steady || $urandom_range(99) >= 30;
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom();
    if (r < 75) return $urandom_range(40) - 20;
    if (r < 85) begin
      case ($urandom_range(3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        default: return '0;
      endcase
    end
    return $urandom_range(1000);
  endfunction

  task automatic send_word(input logic [VAL_W-1:0] value, input logic last);
    sample_word_t w;
    w.value = value;
    w.last  = last;
    samples_to_send = {samples_to_send, w};
  endtask

  task automatic send_run(input int len, input bit close);
    for (int k = 0; k < len; k++) send_word(pick_sample(), close && k == len - 1);
  endtask

  // wait until the unit has taken every word and returned every result
  task automatic wait_idle();
    do @(posedge clk); while (samples_to_send.size() != 0 || push || sums_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MIN_LEN) min_len_cfg = data;
    else if (idx == CFG_MAX_LEN) max_len_cfg = data;
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  initial begin
    int lo_raw;
    int hi_raw;
    int len;
    int taken;
    int phase;
    int n_random;
    int r;
    bit open;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes under the reset lengths
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'd4, 1'b1);
    wait_idle();
    // writes past the register list are dropped
    write_reg(2'd2, 11'd5);
    write_reg(2'd3, 11'd0);
    // sequence shorter than min_len: no valid run
    write_reg(CFG_MIN_LEN, 11'd3);
    send_word(32'd10, 1'b0);
    send_word(32'd20, 1'b1);
    wait_idle();
    // zero lengths clamp up to one
    write_reg(CFG_MIN_LEN, 11'd0);
    write_reg(CFG_MAX_LEN, 11'd0);
    send_word(32'd3, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'd4, 1'b1);
    wait_idle();
    // max_len below min_len acts as min_len
    write_reg(CFG_MIN_LEN, 11'd4);
    write_reg(CFG_MAX_LEN, 11'd2);
    for (int k = 1; k <= 5; k++) send_word(k, k == 5);
    wait_idle();
    // lengths above the window clamp to it
    write_reg(CFG_MIN_LEN, 11'd2047);
    write_reg(CFG_MAX_LEN, 11'd2047);
    send_word(32'd9, 1'b1);
    wait_idle();
    // register change in the middle of a sequence
    write_reg(CFG_MIN_LEN, 11'd1);
    write_reg(CFG_MAX_LEN, 11'd2);
    send_word(32'd5, 1'b0);
    send_word(-32'sd8, 1'b0);
    send_word(32'd6, 1'b0);
    wait_idle();
    write_reg(CFG_MAX_LEN, 11'd3);
    send_word(32'd1, 1'b0);
    send_word(32'd2, 1'b1);
    wait_idle();

    // one long sequence: rising prefixes fill the candidate queue until it
    // drops its oldest entry; min_len then jumps to the window size and the
    // sequence runs past the item cap
    write_reg(CFG_MIN_LEN, 11'd1);
    write_reg(CFG_MAX_LEN, LEN_W'(MAX_WINDOW));
    for (int k = 0; k < MAX_WINDOW + 14; k++) send_word($urandom_range(32'h7fff_ffff, 1), 1'b0);
    wait_idle();
    write_reg(CFG_MIN_LEN, LEN_W'(MAX_WINDOW));
    send_run(ITEM_CAP - MAX_WINDOW, 1'b1);

    // random phases: new lengths each phase, sequences sometimes left open across it
    phase = 0;
    n_random = 0;
    open = 1'b0;
    while (n_random < RANDOM_WORDS) begin
      wait_idle();
      r = $urandom_range(99);
      if (r < 50) lo_raw = $urandom_range(6, 1);
      else if (r < 70) lo_raw = $urandom_range(40, 7);
      else if (r < 85) lo_raw = $urandom_range(2047);
      else lo_raw = 1;
      r = $urandom_range(99);
      if (r < 40) hi_raw = lo_raw + $urandom_range(10);
      else if (r < 70) hi_raw = $urandom_range(2047);
      else if (r < 85) hi_raw = 1024;
      else hi_raw = $urandom_range(lo_raw);
      write_reg(CFG_MIN_LEN, LEN_W'(lo_raw));
      write_reg(CFG_MAX_LEN, LEN_W'(hi_raw));
      steady = (phase >= 3 && phase <= 5);
      taken = 0;
      while (taken < 90) begin
        r = $urandom_range(99);
        if (r < 60) len = $urandom_range(10, 1);
        else if (r < 90) len = $urandom_range(40, 1);
        else len = $urandom_range(200, 41);
        open = (taken + len >= 90) && ($urandom_range(2) == 0);
        send_run(len, !open);
        taken += len;
      end
      n_random += taken;
      phase++;
    end
    steady = 1'b0;
    if (open) send_run(1, 1'b1);
    wait_idle();

    $display("covered %0d input words and %0d results (%0d with no valid run)",
             n_words, n_results, n_no_run);
    $display("%0d register writes over %0d random length settings", n_writes, phase);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
